// ===== hdl/crsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsg_pkg
// Shared constants and types of the circle and ring span generator: field
// widths, queue entry layout and queue status.
// ----------------------------------------------------------------------------
package crsg_pkg;

   localparam int FRAC_BITS_DEF      = 4;
   localparam int COORD_INT_BITS_DEF = 12;
   localparam int QUEUE_DEPTH_DEF    = 4;

   localparam int RADIUS_W   = 12;
   localparam int THICK_W    = 10;
   localparam int ROW_W      = 12;
   localparam int COLOR_W    = 32;
   localparam int SPAN_X_W   = 13;
   localparam int SPAN_LEN_W = 10;

   // outer radius r+th needs one more bit than r, and so does its root
   localparam int ROOT_W = RADIUS_W + 1;

   localparam int RSP_FIELDS_W = SPAN_X_W + SPAN_LEN_W + ROW_W + COLOR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // up to two spans of one request, left one first
   typedef struct packed {
      logic                  a_valid;
      logic                  b_valid;
      logic [SPAN_X_W-1:0]   a_x;
      logic [SPAN_LEN_W-1:0] a_len;
      logic [SPAN_X_W-1:0]   b_x;
      logic [SPAN_LEN_W-1:0] b_len;
      logic [ROW_W-1:0]      row;
      logic [COLOR_W-1:0]    color;
   } span_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== hdl/crsg_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsg_sqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// word that travels alongside the radicand.
// ----------------------------------------------------------------------------
module crsg_sqrt
   import crsg_pkg::*;
#(
   parameter int ROOT_BITS = ROOT_W,
   parameter int SIDE_W    = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic [2*ROOT_BITS-1:0] rad_in,
   input  wire logic [SIDE_W-1:0]      side_in,
   output logic      [ROOT_BITS-1:0]   root_out,
   output logic      [SIDE_W-1:0]      side_out
);

   localparam int RAD_W = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 2;
   localparam int CUR_W = REM_W + 2;

   logic [RAD_W-1:0]     rad_ff  [ROOT_BITS-1];
   logic [REM_W-1:0]     rem_ff  [ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic [SIDE_W-1:0]    side_ff [ROOT_BITS];

   logic [RAD_W-1:0]     rad_src  [ROOT_BITS];
   logic [REM_W-1:0]     rem_src  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_src [ROOT_BITS];
   logic [SIDE_W-1:0]    side_src [ROOT_BITS];

   logic [RAD_W-1:0]     rad_in_s  [ROOT_BITS];
   logic [REM_W-1:0]     rem_in_s  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_in_s [ROOT_BITS];

   genvar k;
   generate
      for (k = 0; k < ROOT_BITS; k++) begin : g_stage
         logic [CUR_W-1:0] cur;
         logic [CUR_W-1:0] trial;

         if (k == 0) begin : g_first
            assign rad_src[k]  = rad_in;
            assign rem_src[k]  = '0;
            assign root_src[k] = '0;
            assign side_src[k] = side_in;
         end else begin : g_next
            assign rad_src[k]  = rad_ff[k-1];
            assign rem_src[k]  = rem_ff[k-1];
            assign root_src[k] = root_ff[k-1];
            assign side_src[k] = side_ff[k-1];
         end

         // bring down the next two radicand bits, try root*4+1
         assign cur   = {rem_src[k], rad_src[k][RAD_W-1 -: 2]};
         assign trial = CUR_W'({root_src[k], 2'b01});

         always_comb begin
            rad_in_s[k] = rad_src[k] << 2;
            if (cur >= trial) begin
               rem_in_s[k]  = REM_W'(cur - trial);
               root_in_s[k] = {root_src[k][ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in_s[k]  = REM_W'(cur);
               root_in_s[k] = {root_src[k][ROOT_BITS-2:0], 1'b0};
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_BITS; i++) begin
            side_ff[i] <= '0;
         end
      end else if (enable) begin
         for (int i = 0; i < ROOT_BITS; i++) begin
            side_ff[i] <= side_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < ROOT_BITS; i++) begin
            root_ff[i] <= root_in_s[i];
         end
         for (int i = 0; i < ROOT_BITS - 1; i++) begin
            rad_ff[i] <= rad_in_s[i];
            rem_ff[i] <= rem_in_s[i];
         end
      end
   end

   assign root_out = root_ff[ROOT_BITS-1];
   assign side_out = side_ff[ROOT_BITS-1];

endmodule
`default_nettype wire

// ===== hdl/crsg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsg_front
// Request pipeline: row offset, chord tests, squares, radicands, two square
// roots and span end points. Pushes one queue entry per request with spans.
// ----------------------------------------------------------------------------
module crsg_front
   import crsg_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int COORD_INT_BITS = COORD_INT_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      in_valid,
   output logic                                           in_ready,
   input  wire logic                                      ring_mode,
   input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] center_x,
   input  wire logic signed [COORD_INT_BITS+FRAC_BITS-1:0] center_y,
   input  wire logic        [RADIUS_W-1:0]                radius,
   input  wire logic        [THICK_W-1:0]                 thickness,
   input  wire logic signed [ROW_W-1:0]                   row,
   input  wire logic        [COLOR_W-1:0]                 color,
   output logic                                           push,
   output span_entry_type                                 push_entry,
   input  wire queue_status_type                          q_status
);

   localparam int CW     = COORD_INT_BITS + FRAC_BITS;
   localparam int DYW    = FRAC_BITS + ((COORD_INT_BITS > ROW_W) ? COORD_INT_BITS : ROW_W) + 1;
   localparam int CMP_W  = (DYW > ROOT_W) ? DYW : ROOT_W;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int SUM_W  = ((CW > ROOT_W + 1) ? CW : ROOT_W + 1) + 1;
   localparam int DIF_W  = SUM_W + 1;
   localparam int SIDE_W = 3 + CW + ROW_W + COLOR_W;
   localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((2 ** FRAC_BITS) - 1);

   // fixed point to pixel, truncated toward zero
   function automatic logic signed [SUM_W-1:0] to_px(input logic signed [SUM_W-1:0] q);
      logic signed [SUM_W-1:0] biased;
      biased = q[SUM_W-1] ? q + BIAS : q;
      return biased >>> FRAC_BITS;
   endfunction

   logic en;

   // stage 1: row offset and radii
   logic                    s1_valid_ff, s1_ring_ff;
   logic signed [DYW-1:0]   s1_dy_ff;
   logic [ROOT_W-1:0]       s1_rout_ff;
   logic [RADIUS_W-1:0]     s1_rin_ff;
   logic signed [CW-1:0]    s1_cx_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [COLOR_W-1:0]      s1_color_ff;
   logic signed [DYW-1:0]   s1_dy_in;
   logic [ROOT_W-1:0]       s1_rout_in;
   logic [RADIUS_W-1:0]     s1_rin_in;

   // stage 2: |dy| and chord tests
   logic                    s2_valid_ff, s2_ring_ff, s2_hit_ff, s2_inner_ff;
   logic [ROOT_W-1:0]       s2_ady_ff, s2_rout_ff;
   logic [RADIUS_W-1:0]     s2_rin_ff;
   logic signed [CW-1:0]    s2_cx_ff;
   logic [ROW_W-1:0]        s2_row_ff;
   logic [COLOR_W-1:0]      s2_color_ff;
   logic [DYW-1:0]          s2_ady_full;
   logic                    s2_hit_in, s2_inner_in;

   // stage 3: squares
   logic                    s3_valid_ff, s3_ring_ff, s3_hit_ff, s3_inner_ff;
   logic [SQ_W-1:0]         s3_sq_a_ff, s3_sq_o_ff, s3_sq_i_ff;
   logic signed [CW-1:0]    s3_cx_ff;
   logic [ROW_W-1:0]        s3_row_ff;
   logic [COLOR_W-1:0]      s3_color_ff;

   // stage 4: radicands
   logic                    s4_valid_ff, s4_ring_ff, s4_hit_ff, s4_inner_ff;
   logic [SQ_W-1:0]         s4_rad_o_ff, s4_rad_i_ff;
   logic signed [CW-1:0]    s4_cx_ff;
   logic [ROW_W-1:0]        s4_row_ff;
   logic [COLOR_W-1:0]      s4_color_ff;

   // root outputs
   logic [ROOT_W-1:0]       root_o, root_i;
   logic [SIDE_W-1:0]       side_o;
   logic                    side_i;
   logic                    r_valid, r_hit, r_ring;
   logic signed [CW-1:0]    r_cx;
   logic [ROW_W-1:0]        r_row;
   logic [COLOR_W-1:0]      r_color;
   logic signed [SUM_W-1:0] r_cx_e, r_ho_e, r_hi_e;

   // stage 5: pixel ends
   logic                    s5_valid_ff, s5_ring_ff, s5_hit_ff, s5_inner_ff;
   logic signed [SUM_W-1:0] s5_xo0_ff, s5_xo1_ff, s5_xi0_ff, s5_xi1_ff;
   logic [ROW_W-1:0]        s5_row_ff;
   logic [COLOR_W-1:0]      s5_color_ff;

   // stage 6: spans
   logic                    s6_valid_ff;
   span_entry_type          s6_entry_ff;
   span_entry_type          s6_entry_in;
   logic signed [DIF_W-1:0] xo0, xo1, xi0, xi1, end_a;

   assign en       = !s6_valid_ff || !q_status.full;
   assign in_ready = en;

   assign s1_dy_in   = (DYW'(row) <<< FRAC_BITS) - DYW'(center_y);
   assign s1_rout_in = ring_mode ? ROOT_W'(radius) + ROOT_W'(thickness) : ROOT_W'(radius);
   assign s1_rin_in  = (radius >= RADIUS_W'(thickness)) ? radius - RADIUS_W'(thickness)
                                                        : RADIUS_W'(thickness) - radius;

   assign s2_ady_full = s1_dy_ff[DYW-1] ? DYW'(-s1_dy_ff) : DYW'(s1_dy_ff);
   assign s2_hit_in   = CMP_W'(s2_ady_full) <= CMP_W'(s1_rout_ff);
   assign s2_inner_in = s1_ring_ff && (CMP_W'(s2_ady_full) <= CMP_W'(s1_rin_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= r_valid;
         s6_valid_ff <= s5_valid_ff && (s6_entry_in.a_valid || s6_entry_in.b_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ring_ff  <= ring_mode;
         s1_dy_ff    <= s1_dy_in;
         s1_rout_ff  <= s1_rout_in;
         s1_rin_ff   <= s1_rin_in;
         s1_cx_ff    <= center_x;
         s1_row_ff   <= row;
         s1_color_ff <= color;

         s2_ring_ff  <= s1_ring_ff;
         s2_hit_ff   <= s2_hit_in;
         s2_inner_ff <= s2_inner_in;
         s2_ady_ff   <= s2_ady_full[ROOT_W-1:0];
         s2_rout_ff  <= s1_rout_ff;
         s2_rin_ff   <= s1_rin_ff;
         s2_cx_ff    <= s1_cx_ff;
         s2_row_ff   <= s1_row_ff;
         s2_color_ff <= s1_color_ff;

         s3_ring_ff  <= s2_ring_ff;
         s3_hit_ff   <= s2_hit_ff;
         s3_inner_ff <= s2_inner_ff;
         s3_sq_a_ff  <= SQ_W'(s2_ady_ff) * SQ_W'(s2_ady_ff);
         s3_sq_o_ff  <= SQ_W'(s2_rout_ff) * SQ_W'(s2_rout_ff);
         s3_sq_i_ff  <= SQ_W'(s2_rin_ff) * SQ_W'(s2_rin_ff);
         s3_cx_ff    <= s2_cx_ff;
         s3_row_ff   <= s2_row_ff;
         s3_color_ff <= s2_color_ff;

         // wraps when the row misses a circle, the hit flags mask that
         s4_ring_ff  <= s3_ring_ff;
         s4_hit_ff   <= s3_hit_ff;
         s4_inner_ff <= s3_inner_ff;
         s4_rad_o_ff <= s3_sq_o_ff - s3_sq_a_ff;
         s4_rad_i_ff <= s3_sq_i_ff - s3_sq_a_ff;
         s4_cx_ff    <= s3_cx_ff;
         s4_row_ff   <= s3_row_ff;
         s4_color_ff <= s3_color_ff;

         s5_ring_ff  <= r_ring;
         s5_hit_ff   <= r_hit;
         s5_inner_ff <= side_i;
         s5_xo0_ff   <= to_px(r_cx_e - r_ho_e);
         s5_xo1_ff   <= to_px(r_cx_e + r_ho_e);
         s5_xi0_ff   <= to_px(r_cx_e - r_hi_e);
         s5_xi1_ff   <= to_px(r_cx_e + r_hi_e);
         s5_row_ff   <= r_row;
         s5_color_ff <= r_color;

         s6_entry_ff <= s6_entry_in;
      end
   end

   crsg_sqrt #(
      .ROOT_BITS (ROOT_W),
      .SIDE_W    (SIDE_W)
   ) u_sqrt_outer (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .rad_in   (s4_rad_o_ff),
      .side_in  ({s4_valid_ff, s4_hit_ff, s4_ring_ff, s4_cx_ff, s4_row_ff, s4_color_ff}),
      .root_out (root_o),
      .side_out (side_o)
   );

   crsg_sqrt #(
      .ROOT_BITS (ROOT_W),
      .SIDE_W    (1)
   ) u_sqrt_inner (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .rad_in   (s4_rad_i_ff),
      .side_in  (s4_inner_ff),
      .root_out (root_i),
      .side_out (side_i)
   );

   assign {r_valid, r_hit, r_ring, r_cx, r_row, r_color} = side_o;
   assign r_cx_e = SUM_W'(r_cx);
   assign r_ho_e = SUM_W'(root_o);
   assign r_hi_e = SUM_W'(root_i);

   assign xo0   = DIF_W'(s5_xo0_ff);
   assign xo1   = DIF_W'(s5_xo1_ff);
   assign xi0   = DIF_W'(s5_xi0_ff);
   assign xi1   = DIF_W'(s5_xi1_ff);
   // left span ends just before the inner chord when there is one
   assign end_a = s5_inner_ff ? xi0 - DIF_W'(1) : xo1;

   always_comb begin
      s6_entry_in.a_valid = s5_hit_ff && (s5_ring_ff ? (end_a >= xo0) : (xo1 > xo0));
      s6_entry_in.a_x     = SPAN_X_W'(xo0);
      s6_entry_in.a_len   = SPAN_LEN_W'(end_a - xo0 + DIF_W'(1));
      s6_entry_in.b_valid = s5_hit_ff && s5_inner_ff && (xo1 > xi1);
      s6_entry_in.b_x     = SPAN_X_W'(xi1 + DIF_W'(1));
      s6_entry_in.b_len   = SPAN_LEN_W'(xo1 - xi1);
      s6_entry_in.row     = s5_row_ff;
      s6_entry_in.color   = s5_color_ff;
   end

   assign push       = s6_valid_ff && !q_status.full;
   assign push_entry = s6_entry_ff;

endmodule
`default_nettype wire

// ===== hdl/crsg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsg_queue
// Short first-in first-out queue of span entries between the request
// pipeline and the span emitter.
// ----------------------------------------------------------------------------
module crsg_queue
   import crsg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire span_entry_type   push_entry,
   input  wire logic             pop,
   output span_entry_type        head,
   output queue_status_type      status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   span_entry_type   entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== hdl/crsg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsg_back
// Span emitter: takes queue entries and sends their one or two spans as
// result words, marking the last span of each request.
// ----------------------------------------------------------------------------
module crsg_back
   import crsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire span_entry_type        head,
   input  wire queue_status_type      q_status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  second_ff, second_in;
   logic                  load, emit, use_b;
   logic [SPAN_X_W-1:0]   sel_x;
   logic [SPAN_LEN_W-1:0] sel_len;

   assign load  = !rsp_valid_ff || rsp_tready;
   assign emit  = load && !q_status.empty;
   // right span goes out once the left one is gone or when there is no left one
   assign use_b = second_ff || !head.a_valid;

   assign sel_x   = use_b ? head.b_x : head.a_x;
   assign sel_len = use_b ? head.b_len : head.a_len;

   always_comb begin
      rsp_valid_in = load ? !q_status.empty : rsp_valid_ff;
      rsp_data_in  = RSP_DATA_W'({head.color, head.row, sel_len, sel_x});
      rsp_last_in  = use_b || !head.b_valid;
      second_in    = second_ff;
      if (emit) begin
         second_in = !use_b && head.b_valid;
      end
   end

   assign pop = emit && rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hdl/circle_ring_span_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circle_ring_span_generator
// Scanline span generator for filled discs and rings.
// ----------------------------------------------------------------------------
// Each request names a disc or ring in Q.FRAC_BITS fixed point and one row;
// the block answers with zero, one or two spans (disc at most one, ring two
// when the inner circle splits the row), the last of them flagged on tlast.
// A request with no span produces no word. Requests are taken one per cycle
// while the span queue has room; the request pipeline runs 19 stages
// (offset, chord tests, squares, radicands, a 13-stage pipelined square root
// pair, end points, spans), and with the queue empty a span passes from the
// spans stage through the queue into the registered result port. The result
// side sends one span per cycle while rsp_tready is high, so a stream of
// two-span rings fills the span queue; when the span queue fills, the whole
// request pipeline holds and req_tready drops.
// ----------------------------------------------------------------------------
module circle_ring_span_generator
   import crsg_pkg::*;
#(
   parameter int FRAC_BITS      = FRAC_BITS_DEF,
   parameter int COORD_INT_BITS = COORD_INT_BITS_DEF,
   parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // center_x, center_y, radius, thickness, row, color
   input  wire logic [((2*(COORD_INT_BITS+FRAC_BITS) + RADIUS_W + THICK_W + ROW_W
                        + COLOR_W + 7) / 8) * 8 - 1:0] req_tdata,
   // ring_mode
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // span_x, span_len, span_row, span_color
   output logic [RSP_DATA_W-1:0]                      rsp_tdata,
   // last_span
   output logic                                       rsp_tlast
);

   localparam int CW = COORD_INT_BITS + FRAC_BITS;

   localparam int OFS_CY  = CW;
   localparam int OFS_R   = 2 * CW;
   localparam int OFS_TH  = OFS_R + RADIUS_W;
   localparam int OFS_ROW = OFS_TH + THICK_W;
   localparam int OFS_COL = OFS_ROW + ROW_W;

   logic signed [CW-1:0]    center_x, center_y;
   logic [RADIUS_W-1:0]     radius;
   logic [THICK_W-1:0]      thickness;
   logic signed [ROW_W-1:0] row;
   logic [COLOR_W-1:0]      color;

   logic                    q_push, q_pop;
   span_entry_type          q_push_entry, q_head;
   queue_status_type        q_status;

   assign center_x  = req_tdata[CW-1:0];
   assign center_y  = req_tdata[OFS_CY +: CW];
   assign radius    = req_tdata[OFS_R +: RADIUS_W];
   assign thickness = req_tdata[OFS_TH +: THICK_W];
   assign row       = req_tdata[OFS_ROW +: ROW_W];
   assign color     = req_tdata[OFS_COL +: COLOR_W];

   crsg_front #(
      .FRAC_BITS      (FRAC_BITS),
      .COORD_INT_BITS (COORD_INT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .ring_mode  (req_tuser),
      .center_x   (center_x),
      .center_y   (center_y),
      .radius     (radius),
      .thickness  (thickness),
      .row        (row),
      .color      (color),
      .push       (q_push),
      .push_entry (q_push_entry),
      .q_status   (q_status)
   );

   crsg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   crsg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a queued entry always carries at least one span
   a_entry_has_span: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_entry.a_valid || q_push_entry.b_valid))
      else $error("queue entry without span");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("span queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("span queue underflow");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_status.empty)
      else $error("span queue lost an entry");

endmodule
`default_nettype wire
